// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL of the float vector ALU.
// Depends on nothing; files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FVA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fva_pkg.sv =====
// Shared types, codes and the rounding function of the float vector ALU.
// Depends on nothing; every other file but assert_macros.svh uses it.
`timescale 1ns / 1ps

package fva_pkg;

    localparam int unsigned CmdW   = 3;
    localparam int unsigned DataW  = 32;
    localparam int unsigned SigW   = 24;
    localparam int unsigned WorkW  = 48;
    localparam int unsigned ExpW   = 12;
    localparam int unsigned DivCntW = 6;
    localparam logic [DivCntW-1:0] DivLastStep = 6'd47;

    typedef logic [CmdW-1:0] t_cmd;

    localparam t_cmd CMD_ADD = 3'd0;
    localparam t_cmd CMD_SUB = 3'd1;
    localparam t_cmd CMD_MUL = 3'd2;
    localparam t_cmd CMD_DIV = 3'd3;
    localparam t_cmd CMD_DOT = 3'd4;

    // Magnitude bits of 0.00001 in single precision.
    localparam logic [30:0] NEAR_ZERO_MAG = 31'h3727C5AC;
    localparam logic [DataW-1:0] CANON_NAN = 32'h7FC00000;

    typedef struct packed {
        logic load_in;
        logic check;
        logic norm_step;
        logic div_init;
        logic div_step;
        logic round;
        logic dot_load;
        logic dot_store;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd_ok;
        logic near_zero;
        logic special;
        logic op_div;
        logic norm_done;
        logic div_last;
        logic is_dot;
        logic last;
        logic out_free;
    } t_dp_sts;

    // Rounds a normalized significand (leading one at bit 26 unless zero) to
    // nearest even and packs it, handling subnormal results and overflow.
    function automatic logic [DataW-1:0] round_pack(
        input logic                   sign,
        input logic signed [ExpW-1:0] exp_in,
        input logic [26:0]            man,
        input logic                   sticky
    );
        logic [26:0]            m;
        logic [26:0]            back;
        logic signed [ExpW-1:0] e;
        logic signed [ExpW-1:0] sh_dist;
        logic signed [ExpW-1:0] e_out;
        logic [4:0]             sh;
        logic                   st;
        logic                   up;
        logic [24:0]            m25;
        logic [DataW-1:0]       res;
        m  = man;
        e  = exp_in;
        st = sticky;
        if (e < 12'sd1) begin
            sh_dist = 12'sd1 - e;
            sh      = (sh_dist > 12'sd27) ? 5'd27 : sh_dist[4:0];
            m       = man >> sh;
            back    = m << sh;
            st      = st | (back != man);
            e       = 12'sd1;
        end
        up  = m[2] & (m[1] | m[0] | st | m[3]);
        m25 = {1'b0, m[26:3]} + {24'd0, up};
        if (m25[24]) begin
            e_out = e + 12'sd1;
        end else if (m25[23]) begin
            e_out = e;
        end else begin
            e_out = 12'sd0;
        end
        if ((m25 != 25'd0) && (e_out >= 12'sd255)) begin
            res = {sign, 8'hFF, 23'd0};
        end else begin
            res = {sign, e_out[7:0], m25[22:0]};
        end
        return res;
    endfunction

endpackage

// ===== rtl/fva_if.sv =====
// Handshake channel interfaces for the float vector ALU input and result items.
// Depends on fva_pkg for the field types.
`timescale 1ns / 1ps

interface fva_in_if;
    logic           valid;
    logic           ready;
    fva_pkg::t_cmd  cmd;
    logic [31:0]    a_value;
    logic [31:0]    b_value;
    logic           is_last;

    modport source(output valid, cmd, a_value, b_value, is_last, input ready);
    modport sink(input valid, cmd, a_value, b_value, is_last, output ready);
endinterface

interface fva_out_if;
    logic           valid;
    logic           ready;
    logic [31:0]    value;
    logic           zero_divisor;
    logic           vector_bad;
    logic           end_of_vector;

    modport source(output valid, value, zero_divisor, vector_bad, end_of_vector,
                   input ready);
    modport sink(input valid, value, zero_divisor, vector_bad, end_of_vector,
                 output ready);
endinterface

// ===== rtl/fva_datapath.sv =====
// Floating-point datapath: operand registers, special-case check, multiplier,
// aligner/adder, normalizer, restoring divider, rounding and result register.
// Depends on fva_pkg.
`timescale 1ns / 1ps

module fva_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fva_pkg::t_dp_cmd  i_cmd,
    output fva_pkg::t_dp_sts  o_sts,
    input  fva_pkg::t_cmd     i_in_cmd,
    input  logic [31:0]       i_a_value,
    input  logic [31:0]       i_b_value,
    input  logic              i_is_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [31:0]       o_value,
    output logic              o_zero_divisor,
    output logic              o_vector_bad,
    output logic              o_end_of_vector
);
    import fva_pkg::*;

    // Item registers.
    logic [DataW-1:0] r_a, r_b, r_res, r_dot;
    t_cmd             r_op;
    logic             r_is_dot, r_last, r_nz, r_fault;

    // Working significand, exponent and sign.
    logic [WorkW-1:0]       r_w;
    logic signed [ExpW-1:0] r_exp;
    logic                   r_sign, r_sticky;

    // Divider state.
    logic [SigW:0]        r_rem;
    logic [SigW-1:0]      r_den;
    logic [DivCntW-1:0]   r_div_cnt;

    // Result register.
    logic             r_o_valid;
    logic [DataW-1:0] r_o_value;
    logic             r_o_zd, r_o_bad, r_o_eov;

    // Unpacked operands.
    logic                   a_sub, b_sub, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [SigW-1:0]        sig_a, sig_b;
    logic signed [ExpW-1:0] exp_a, exp_b;
    logic                   sb_eff, prod_sign;

    // Special cases.
    logic             near_zero, special;
    logic [DataW-1:0] spec_val;

    // Add path.
    logic                   a_big, x_sign, y_sign, eff_sub;
    logic [SigW-1:0]        x_sig, y_sig;
    logic signed [ExpW-1:0] x_exp, y_exp, exp_diff;
    logic [WorkW-1:0]       x_full, y_full, y_sh, y_back, y_jam;
    logic [WorkW:0]         sum;

    // Divider step.
    logic             div_ge;
    logic [SigW:0]    div_diff;

    assign a_sub  = (r_a[30:23] == 8'd0);
    assign b_sub  = (r_b[30:23] == 8'd0);
    assign a_nan  = (r_a[30:23] == 8'hFF) && (r_a[22:0] != 23'd0);
    assign b_nan  = (r_b[30:23] == 8'hFF) && (r_b[22:0] != 23'd0);
    assign a_inf  = (r_a[30:23] == 8'hFF) && (r_a[22:0] == 23'd0);
    assign b_inf  = (r_b[30:23] == 8'hFF) && (r_b[22:0] == 23'd0);
    assign a_zero = (r_a[30:0] == 31'd0);
    assign b_zero = (r_b[30:0] == 31'd0);
    assign sig_a  = {~a_sub, r_a[22:0]};
    assign sig_b  = {~b_sub, r_b[22:0]};
    assign exp_a  = a_sub ? 12'sd1 : $signed({4'd0, r_a[30:23]});
    assign exp_b  = b_sub ? 12'sd1 : $signed({4'd0, r_b[30:23]});
    assign sb_eff = r_b[31] ^ (r_op == CMD_SUB);
    assign prod_sign = r_a[31] ^ r_b[31];

    // A NaN divisor has a larger magnitude field and is never flagged.
    assign near_zero = (r_op == CMD_DIV) && (r_b[30:0] < NEAR_ZERO_MAG);

    always_comb begin
        special  = 1'b0;
        spec_val = CANON_NAN;
        case (r_op)
            CMD_ADD, CMD_SUB: begin
                if (a_nan || b_nan || (a_inf && b_inf && (r_a[31] != sb_eff))) begin
                    special = 1'b1;
                end else if (a_inf) begin
                    special  = 1'b1;
                    spec_val = {r_a[31], 8'hFF, 23'd0};
                end else if (b_inf) begin
                    special  = 1'b1;
                    spec_val = {sb_eff, 8'hFF, 23'd0};
                end
            end
            CMD_MUL: begin
                if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
                    special = 1'b1;
                end else if (a_inf || b_inf) begin
                    special  = 1'b1;
                    spec_val = {prod_sign, 8'hFF, 23'd0};
                end
            end
            CMD_DIV: begin
                if (a_nan || b_nan || (a_inf && b_inf)) begin
                    special = 1'b1;
                end else if (a_inf) begin
                    special  = 1'b1;
                    spec_val = {prod_sign, 8'hFF, 23'd0};
                end else if (b_inf || a_zero) begin
                    special  = 1'b1;
                    spec_val = {prod_sign, 31'd0};
                end
            end
            default: begin
                special = 1'b0;
            end
        endcase
    end

    // Alignment and add of the two magnitudes, larger one first.
    always_comb begin
        a_big    = (r_a[30:0] >= r_b[30:0]);
        x_sig    = a_big ? sig_a : sig_b;
        y_sig    = a_big ? sig_b : sig_a;
        x_exp    = a_big ? exp_a : exp_b;
        y_exp    = a_big ? exp_b : exp_a;
        x_sign   = a_big ? r_a[31] : sb_eff;
        y_sign   = a_big ? sb_eff : r_a[31];
        eff_sub  = (x_sign != y_sign);
        exp_diff = x_exp - y_exp;
        x_full   = {x_sig, 24'd0};
        y_full   = {y_sig, 24'd0};
        y_sh     = (exp_diff > 12'sd47) ? '0 : (y_full >> exp_diff[5:0]);
        y_back   = y_sh << exp_diff[5:0];
        y_jam    = y_sh | {{(WorkW-1){1'b0}}, (y_back != y_full)};
        sum      = eff_sub ? ({1'b0, x_full} - {1'b0, y_jam})
                           : ({1'b0, x_full} + {1'b0, y_jam});
    end

    assign div_ge   = (r_rem >= {1'b0, r_den});
    assign div_diff = div_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_fault   <= 1'b0;
            r_dot     <= '0;
            r_nz      <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_a      <= i_a_value;
                r_b      <= i_b_value;
                r_op     <= (i_in_cmd == CMD_DOT) ? CMD_MUL : i_in_cmd;
                r_is_dot <= (i_in_cmd == CMD_DOT);
                r_last   <= i_is_last;
                r_nz     <= 1'b0;
            end

            if (i_cmd.check) begin
                r_sticky <= 1'b0;
                if (near_zero) begin
                    r_nz <= 1'b1;
                end else if (special) begin
                    r_res <= spec_val;
                end else begin
                    case (r_op)
                        CMD_MUL: begin
                            r_w    <= sig_a * sig_b;
                            r_exp  <= exp_a + exp_b - 12'sd126;
                            r_sign <= prod_sign;
                        end
                        CMD_DIV: begin
                            r_w    <= {sig_a, 24'd0};
                            r_exp  <= exp_a - exp_b + 12'sd127;
                            r_sign <= prod_sign;
                            r_den  <= sig_b;
                        end
                        default: begin
                            if (sum[WorkW]) begin
                                r_w      <= sum[WorkW:1];
                                r_sticky <= sum[0];
                                r_exp    <= x_exp + 12'sd1;
                            end else begin
                                r_w   <= sum[WorkW-1:0];
                                r_exp <= x_exp;
                            end
                            // An exact zero is +0 unless both addends were -0.
                            r_sign <= (sum == '0) ? (x_sign & ~eff_sub) : x_sign;
                        end
                    endcase
                end
            end

            if (i_cmd.norm_step && !o_sts.norm_done) begin
                if (r_w[WorkW-1:WorkW-8] == 8'd0) begin
                    r_w   <= r_w << 8;
                    r_exp <= r_exp - 12'sd8;
                end else begin
                    r_w   <= r_w << 1;
                    r_exp <= r_exp - 12'sd1;
                end
            end

            if (i_cmd.div_init) begin
                r_rem     <= {1'b0, r_w[WorkW-1:WorkW-SigW]};
                r_w       <= '0;
                r_div_cnt <= '0;
            end

            if (i_cmd.div_step) begin
                r_w       <= {r_w[WorkW-2:0], div_ge};
                r_rem     <= {div_diff[SigW-1:0], 1'b0};
                r_div_cnt <= r_div_cnt + 6'd1;
                r_sticky  <= (div_diff != '0);
            end

            if (i_cmd.round) begin
                r_res <= round_pack(r_sign, r_exp, r_w[WorkW-1:WorkW-27],
                                    (r_w[WorkW-28:0] != '0) | r_sticky);
            end

            if (i_cmd.dot_load) begin
                r_a  <= r_dot;
                r_b  <= r_res;
                r_op <= CMD_ADD;
            end

            if (i_cmd.dot_store) begin
                r_dot <= r_res;
            end

            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
                r_o_value <= r_nz ? '0 : r_res;
                r_o_zd    <= r_nz;
                r_o_bad   <= r_last & (r_fault | r_nz);
                r_o_eov   <= r_last;
                if (r_last) begin
                    r_fault <= 1'b0;
                    r_dot   <= '0;
                end else begin
                    r_fault <= r_fault | r_nz;
                end
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.cmd_ok    = (i_in_cmd <= CMD_DOT);
        o_sts.near_zero = near_zero;
        o_sts.special   = special;
        o_sts.op_div    = (r_op == CMD_DIV);
        o_sts.norm_done = r_w[WorkW-1] || (r_w == '0);
        o_sts.div_last  = (r_div_cnt == DivLastStep);
        o_sts.is_dot    = r_is_dot;
        o_sts.last      = r_last;
        o_sts.out_free  = !r_o_valid || i_ready;
    end

    assign o_valid         = r_o_valid;
    assign o_value         = r_o_value;
    assign o_zero_divisor  = r_o_zd;
    assign o_vector_bad    = r_o_bad;
    assign o_end_of_vector = r_o_eov;

endmodule

// ===== rtl/fva_ctrl.sv =====
// Sequencer of the float vector ALU: walks one item through check, normalize,
// divide, round and the dot-product accumulate, then hands it to the output.
// Depends on fva_pkg.
`timescale 1ns / 1ps

module fva_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fva_pkg::t_dp_sts  i_sts,
    output fva_pkg::t_dp_cmd  o_cmd
);
    import fva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_NORM,
        S_DIV_LOAD,
        S_DIV,
        S_ROUND,
        S_POST,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_div_pre, n_div_pre;
    logic   r_dot_add, n_dot_add;

    always_comb begin
        n_state   = r_state;
        n_div_pre = r_div_pre;
        n_dot_add = r_dot_add;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_dot_add     = 1'b0;
                    if (i_sts.cmd_ok) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_sts.near_zero) begin
                    n_state = S_EMIT;
                end else if (i_sts.special) begin
                    n_state = S_POST;
                end else begin
                    n_div_pre = i_sts.op_div;
                    n_state   = S_NORM;
                end
            end
            S_NORM: begin
                o_cmd.norm_step = 1'b1;
                if (i_sts.norm_done) begin
                    n_state = r_div_pre ? S_DIV_LOAD : S_ROUND;
                end
            end
            S_DIV_LOAD: begin
                o_cmd.div_init = 1'b1;
                n_div_pre      = 1'b0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_NORM;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_POST;
            end
            S_POST: begin
                if (i_sts.is_dot && !r_dot_add) begin
                    o_cmd.dot_load = 1'b1;
                    n_dot_add      = 1'b1;
                    n_state        = S_CHECK;
                end else if (i_sts.is_dot && !i_sts.last) begin
                    o_cmd.dot_store = 1'b1;
                    n_state         = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_pre <= 1'b0;
            r_dot_add <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_div_pre <= n_div_pre;
            r_dot_add <= n_dot_add;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/float_vector_alu.sv =====
// Float vector ALU, one item at a time. Depends on fva_pkg, fva_if, fva_ctrl, fva_datapath and assert_macros.svh.
// Add, subtract, multiply, divide and a last dot element each leave a registered result, as do
// a near-zero divisor and a NaN or infinity operand; a dot element that is not last stores its
// sum instead. The input reopens as the result or the sum is registered, and an item with an
// unused code is taken and dropped without a result.
// Synchronous active-low reset clears the sequencer, result valid, divide fault and dot sum (+0).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module float_vector_alu (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fva_in_if.sink     i_in,
    fva_out_if.source  o_out
);
    import fva_pkg::*;

    // The sequencer and the datapath talk only through these two bundles.
    // Cancellation and subnormal operands add normalizer steps, each shifting by 8 bits or by 1
    // to remove leading zeros, and a full result register holds an item in place.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The sequencer accepts an item only in its idle state. An item with an
    // unused operation code is taken and dropped in that same cycle.
    fva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the operands, the running dot sum, the sticky divide
    // fault and a result register, so a finished item can wait on the output
    // while the next item is already being worked on.
    fva_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .o_sts           (dp_sts),
        .i_in_cmd        (i_in.cmd),
        .i_a_value       (i_in.a_value),
        .i_b_value       (i_in.b_value),
        .i_is_last       (i_in.is_last),
        .o_valid         (o_out.valid),
        .i_ready         (o_out.ready),
        .o_value         (o_out.value),
        .o_zero_divisor  (o_out.zero_divisor),
        .o_vector_bad    (o_out.vector_bad),
        .o_end_of_vector (o_out.end_of_vector)
    );

    // A flagged divide element always reports a zero value.
    `FVA_ASSERT_IMPL(a_zd_value, i_clk, i_rst_n, o_out.valid && o_out.zero_divisor, o_out.value == 32'd0, "flagged element with nonzero value")
    // The vector fault is only reported on the final element.
    `FVA_ASSERT_IMPL(a_bad_eov, i_clk, i_rst_n, o_out.valid && o_out.vector_bad, o_out.end_of_vector, "vector fault away from end of vector")
    // Every NaN result leaves as the canonical quiet NaN.
    `FVA_ASSERT_IMPL(a_nan_canon, i_clk, i_rst_n, o_out.valid && (o_out.value[30:23] == 8'hFF) && (o_out.value[22:0] != 23'd0), o_out.value == CANON_NAN, "non-canonical NaN result")
    // A valid operation keeps the input closed while it is being worked on.
    `FVA_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.cmd <= CMD_DOT), !i_in.ready, "input accepted while an item is in progress")

endmodule

// ===== bench/tb_float_vector_alu.sv =====
// Self-checking testbench for the float vector ALU: directed rows, then random vectors.
// Depends on fva_pkg, the fva_in_if / fva_out_if interfaces and the float_vector_alu RTL.
`timescale 1ns / 1ps

module tb_float_vector_alu;
    import fva_pkg::*;

    // Codes 5 to 7 are unused and must be dropped by the block.
    localparam t_cmd CMD_UNUSED_LO = 3'd5;
    localparam t_cmd CMD_UNUSED_HI = 3'd7;

    localparam logic [31:0] F_ONE   = 32'h3F800000;
    localparam logic [31:0] F_TWO   = 32'h40000000;
    localparam logic [31:0] F_INF   = 32'h7F800000;
    localparam logic [31:0] F_MAX   = 32'h7F7FFFFF;
    localparam logic [31:0] F_NEG0  = 32'h80000000;
    localparam logic [31:0] F_SNAN  = 32'h7F800001;
    localparam logic [31:0] F_LIMIT = {1'b0, NEAR_ZERO_MAG};

    localparam int unsigned RandomItems  = 400;
    localparam int unsigned StallLimit   = 3000;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned DrainCycles  = 120;

    typedef struct packed {
        logic [31:0] value;
        logic        zero_divisor;
        logic        vector_bad;
        logic        end_of_vector;
    } t_result;

    typedef struct {
        t_cmd        cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic        last;
        logic        typed;
        t_result     want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    fva_in_if  in_ch();
    fva_out_if out_ch();

    float_vector_alu uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Predictor state: the running dot sum as a bit pattern and the sticky divide fault.
    logic [31:0] acc_sum;
    logic        div_fault;

    t_result     pending_q[$];
    int unsigned mismatches;
    int unsigned items_taken;
    int unsigned results_seen;
    int unsigned flagged_divs;
    int unsigned dot_results;
    bit          stim_done;
    bit          run_over;

    // Typed expectation riding along with the item currently offered.
    logic        cur_typed;
    t_result     cur_want;

    // ---------------------------------------------------------------------------------
    // Float arithmetic. Singles are widened to double, where add, subtract, multiply and
    // divide are exact enough that one final round to single gives the correctly rounded
    // single result. Specials (NaN, infinity) are resolved here, not in real arithmetic.
    // ---------------------------------------------------------------------------------
    function automatic real single_to_real(input logic [31:0] f);
        real         r;
        logic [10:0] de;
        if (f[30:0] == 31'd0) begin
            r = $bitstoreal({f[31], 63'd0});
        end else if (f[30:23] == 8'd0) begin
            r = real'(f[22:0]) / (2.0 ** 149);
            if (f[31]) r = -r;
        end else begin
            // Rebias the exponent from 127 to 1023.
            de = {3'b000, f[30:23]} + 11'd896;
            r  = $bitstoreal({f[31], de, f[22:0], 29'd0});
        end
        return r;
    endfunction

    function automatic logic [31:0] real_to_single(input real r);
        logic [63:0] d;
        longint      e;
        longint      sh;
        longint      base;
        logic [63:0] m;
        logic [63:0] kept;
        logic        guard;
        logic        sticky;
        longint      total;
        d = $realtobits(r);
        if (d[62:0] == 63'd0) begin
            return {d[63], 31'd0};
        end
        e = longint'(d[62:52]) - 1023;
        m = {11'd0, 1'b1, d[51:0]};
        if (e >= -126) begin
            sh   = 29;
            base = (e + 126) << 23;
        end else begin
            sh   = 29 + (-126 - e);
            base = 0;
        end
        if (sh > 60) sh = 60;
        kept   = m >> sh;
        guard  = m[sh-1];
        sticky = (m & ((64'd1 << (sh - 1)) - 64'd1)) != 64'd0;
        kept   = kept + ((guard & (sticky | kept[0])) ? 64'd1 : 64'd0);
        total  = base + longint'(kept);
        if (total >= longint'(F_INF)) begin
            return {d[63], F_INF[30:0]};
        end
        return {d[63], 31'(total)};
    endfunction

    function automatic bit is_nan(input logic [31:0] f);
        return (f[30:23] == 8'hFF) && (f[22:0] != 23'd0);
    endfunction

    function automatic bit is_inf(input logic [31:0] f);
        return f[30:0] == F_INF[30:0];
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b) && (a[31] != b[31])) return CANON_NAN;
        if (is_inf(a)) return a;
        if (is_inf(b)) return b;
        return real_to_single(single_to_real(a) + single_to_real(b));
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if ((is_inf(a) && b[30:0] == 31'd0) || (is_inf(b) && a[30:0] == 31'd0)) begin
            return CANON_NAN;
        end
        if (is_inf(a) || is_inf(b)) return {sgn, F_INF[30:0]};
        return real_to_single(single_to_real(a) * single_to_real(b));
    endfunction

    // The divisor is known not to be near zero here.
    function automatic logic [31:0] fp_div(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (is_nan(a) || is_nan(b)) return CANON_NAN;
        if (is_inf(a) && is_inf(b)) return CANON_NAN;
        if (is_inf(a)) return {sgn, F_INF[30:0]};
        if (is_inf(b)) return {sgn, 31'd0};
        return real_to_single(single_to_real(a) / single_to_real(b));
    endfunction

    // Works out the result of one accepted item and advances the predictor state.
    // Returns 0 when the item gives no result.
    function automatic bit alu_predict(input t_cmd cmd, input logic [31:0] a,
                                       input logic [31:0] b, input logic last,
                                       output t_result res);
        logic [31:0] val;
        logic        flag;
        val  = 32'd0;
        flag = 1'b0;
        res  = '0;
        if (cmd > CMD_DOT) return 0;
        case (cmd)
            CMD_ADD: val = fp_add(a, b);
            CMD_SUB: val = fp_add(a, {~b[31], b[30:0]});
            CMD_MUL: val = fp_mul(a, b);
            CMD_DIV: begin
                // NaN magnitudes sort above the limit, so a NaN divisor is never flagged.
                if (b[30:0] < NEAR_ZERO_MAG) begin
                    flag      = 1'b1;
                    div_fault = 1'b1;
                end else begin
                    val = fp_div(a, b);
                end
            end
            default: begin
                acc_sum = fp_add(acc_sum, fp_mul(a, b));
                if (!last) return 0;
                val = acc_sum;
            end
        endcase
        res.value         = val;
        res.zero_divisor  = flag;
        res.vector_bad    = last & div_fault;
        res.end_of_vector = last;
        if (last) begin
            div_fault = 1'b0;
            acc_sum   = 32'd0;
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // ---------------------------------------------------------------------------------
    // Clock and reset. Reset is held low at the very start and never again.
    // ---------------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------------------------
    // Input side. Every item is accepted on a rising edge with valid and ready both
    // high; the predictor runs on that same edge, with inputs that changed on the falling
    // edge before.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result r;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            if (in_ch.cmd <= CMD_DOT) items_taken++;
            if (alu_predict(in_ch.cmd, in_ch.a_value, in_ch.b_value, in_ch.is_last, r)) begin
                pending_q.push_back(cur_typed ? cur_want : r);
            end
        end
    end

    // Result side: each accepted result is matched against the oldest expectation.
    always @(posedge i_clk) begin
        t_result w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected result", out_ch.value, 32'd0);
            end else begin
                w = pending_q.pop_front();
                if (w.zero_divisor) flagged_divs++;
                if (out_ch.value !== w.value)
                    report_mismatch("value", out_ch.value, w.value);
                if (out_ch.zero_divisor !== w.zero_divisor)
                    report_mismatch("zero_divisor", out_ch.zero_divisor, w.zero_divisor);
                if (out_ch.vector_bad !== w.vector_bad)
                    report_mismatch("vector_bad", out_ch.vector_bad, w.vector_bad);
                if (out_ch.end_of_vector !== w.end_of_vector)
                    report_mismatch("end_of_vector", out_ch.end_of_vector, w.end_of_vector);
            end
        end
    end

    // Receiver: draws one random wait per offered result, with calm stretches where it never
    // waits, and once holds ready low for a long stretch so the block backs up.
    initial begin
        int unsigned wait_left;
        int unsigned hold_left;
        int unsigned cyc;
        bit          held;
        bit          drawn;
        wait_left = 0;
        hold_left = 0;
        cyc       = 0;
        held      = 1'b0;
        drawn     = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) drawn = 1'b0;
            @(negedge i_clk);
            cyc++;
            if (!held && items_taken >= 200) begin
                held      = 1'b1;
                hold_left = HoldCycles;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                if (out_ch.valid && !drawn) begin
                    drawn     = 1'b1;
                    wait_left = ((cyc / 300) % 3 == 2) ? 0 : $urandom_range(0, 3);
                end
                out_ch.ready <= (wait_left == 0);
                if (wait_left > 0) wait_left--;
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (!run_over && quiet >= StallLimit) begin
                $display("[%0t] timeout: no item moved for %0d cycles", $realtime, quiet);
                $display("FAIL float_vector_alu");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Sender.
    // ---------------------------------------------------------------------------------
    int unsigned sent;

    // Offers one item after a drawn gap and returns on the falling edge after acceptance.
    task automatic send_item(input t_cmd cmd, input logic [31:0] a, input logic [31:0] b,
                             input logic last, input logic typed, input t_result want);
        int unsigned gap;
        gap = ((sent / 40) % 4 == 3) ? 0 : $urandom_range(0, 3);
        repeat (gap) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.a_value <= a;
        in_ch.b_value <= b;
        in_ch.is_last <= last;
        cur_typed     <= typed;
        cur_want      <= want;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        @(negedge i_clk);
    endtask

    // Operand mix: ordinary magnitudes in four draws of ten, with raw patterns, specials,
    // subnormals, values around the divide limit and values near both ends of the range.
    function automatic logic [31:0] pick_operand();
        logic [31:0] f;
        f = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: f[30:23] = 8'($urandom_range(120, 134));
            4:          ;
            5: begin
                case ($urandom_range(0, 5))
                    0: f = 32'd0;
                    1: f = F_NEG0;
                    2: f = F_INF;
                    3: f = F_INF | F_NEG0;
                    4: f = CANON_NAN;
                    default: f = F_MAX;
                endcase
            end
            6: f[30:23] = 8'd0;
            7: f = {f[31], NEAR_ZERO_MAG + 31'($urandom_range(0, 4)) - 31'd2};
            8: f[30:23] = 8'($urandom_range(0, 20));
            default: f[30:23] = 8'($urandom_range(230, 254));
        endcase
        return f;
    endfunction

    // Directed rows; a typed expectation appears only where it can be read off at once.
    t_row rows[$] = '{
        '{CMD_ADD, F_ONE, F_ONE, 1'b1, 1'b1, '{F_TWO, 1'b0, 1'b0, 1'b1}},
        '{CMD_SUB, F_ONE, F_ONE, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0, 1'b1}},
        '{CMD_MUL, F_TWO, 32'h40400000, 1'b1, 1'b1, '{32'h40C00000, 1'b0, 1'b0, 1'b1}},
        '{CMD_ADD, F_MAX, F_MAX, 1'b1, 1'b1, '{F_INF, 1'b0, 1'b0, 1'b1}},
        '{CMD_ADD, F_INF, F_INF | F_NEG0, 1'b1, 1'b1, '{CANON_NAN, 1'b0, 1'b0, 1'b1}},
        '{CMD_MUL, F_INF, 32'd0, 1'b1, 1'b1, '{CANON_NAN, 1'b0, 1'b0, 1'b1}},
        '{CMD_ADD, F_SNAN, F_ONE, 1'b1, 1'b1, '{CANON_NAN, 1'b0, 1'b0, 1'b1}},
        '{CMD_DIV, F_ONE, 32'd0, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b1}},
        // A flagged element leaves a fault that the next last element reports.
        '{CMD_DIV, F_ONE, F_NEG0, 1'b0, 1'b1, '{32'd0, 1'b1, 1'b0, 1'b0}},
        '{CMD_DIV, 32'h40C00000, F_TWO, 1'b1, 1'b1, '{32'h40400000, 1'b0, 1'b1, 1'b1}},
        '{CMD_DIV, F_ONE, F_LIMIT, 1'b1, 1'b0, '0},
        '{CMD_DIV, F_ONE, F_LIMIT - 32'd1, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b1}},
        '{CMD_DIV, F_ONE, 32'h00000001, 1'b1, 1'b1, '{32'd0, 1'b1, 1'b1, 1'b1}},
        '{CMD_DIV, F_ONE, CANON_NAN, 1'b1, 1'b1, '{CANON_NAN, 1'b0, 1'b0, 1'b1}},
        '{CMD_MUL, 32'h00000001, 32'h3F000000, 1'b1, 1'b0, '0},
        '{CMD_ADD, 32'h00000001, 32'h807FFFFF, 1'b1, 1'b0, '0},
        '{CMD_DOT, F_ONE, F_TWO, 1'b0, 1'b0, '0},
        '{CMD_DOT, 32'h40400000, 32'h40800000, 1'b1, 1'b1,
          '{32'h41600000, 1'b0, 1'b0, 1'b1}},
        '{CMD_UNUSED_LO, F_ONE, F_ONE, 1'b1, 1'b0, '0},
        '{CMD_UNUSED_HI, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0, '0},
        '{CMD_DOT, F_ONE, F_ONE, 1'b1, 1'b1, '{F_ONE, 1'b0, 1'b0, 1'b1}},
        '{CMD_SUB, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b1, 1'b0, '0},
        '{CMD_MUL, F_MAX, F_MAX, 1'b1, 1'b1, '{F_INF, 1'b0, 1'b0, 1'b1}},
        '{CMD_DIV, F_INF, F_INF, 1'b1, 1'b1, '{CANON_NAN, 1'b0, 1'b0, 1'b1}},
        '{CMD_ADD, F_NEG0, F_NEG0, 1'b1, 1'b1, '{F_NEG0, 1'b0, 1'b0, 1'b1}}
    };

    initial begin
        int unsigned len;
        t_cmd        vec_cmd;
        t_cmd        cmd;
        logic        last;
        acc_sum       = 32'd0;
        div_fault     = 1'b0;
        mismatches    = 0;
        items_taken   = 0;
        results_seen  = 0;
        flagged_divs  = 0;
        dot_results   = 0;
        sent          = 0;
        stim_done     = 1'b0;
        run_over      = 1'b0;
        cur_typed     = 1'b0;
        cur_want      = '0;
        in_ch.valid   = 1'b0;
        in_ch.cmd     = CMD_ADD;
        in_ch.a_value = 32'd0;
        in_ch.b_value = 32'd0;
        in_ch.is_last = 1'b0;

        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        foreach (rows[i]) begin
            send_item(rows[i].cmd, rows[i].a, rows[i].b, rows[i].last,
                      rows[i].typed, rows[i].want);
        end

        // Random vectors: mostly one operation per vector with a closing last element,
        // some mixed vectors, and some noise from unused codes.
        while (items_taken < RandomItems + rows.size()) begin
            len     = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
            vec_cmd = t_cmd'($urandom_range(0, 4));
            for (int unsigned k = 0; k < len; k++) begin
                cmd  = ($urandom_range(0, 6) == 0) ? t_cmd'($urandom_range(0, 4)) : vec_cmd;
                last = (k == len - 1) ? ($urandom_range(0, 15) != 0) : ($urandom_range(0, 19) == 0);
                if ($urandom_range(0, 11) == 0) begin
                    send_item(t_cmd'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                              $urandom, $urandom, 1'($urandom), 1'b0, '0);
                end
                if (cmd == CMD_DOT && last) dot_results++;
                send_item(cmd, pick_operand(), pick_operand(), last, 1'b0, '0);
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        wait (pending_q.size() == 0);
        repeat (DrainCycles) @(posedge i_clk);
        run_over = 1'b1;

        $display("Covered %0d items (%0d results, %0d flagged divisors, %0d random dot sums),",
                 items_taken, results_seen, flagged_divs, dot_results);
        $display("including a long result stall that backed up the input; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && pending_q.size() == 0) begin
            $display("PASS float_vector_alu");
        end else begin
            $display("FAIL float_vector_alu");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fva_pkg.sv
rtl/fva_if.sv
rtl/fva_datapath.sv
rtl/fva_ctrl.sv
rtl/float_vector_alu.sv
bench/tb_float_vector_alu.sv
